### hw/rtl/isbc_pkg.sv
// Shared definitions for the induced subgraph bridgeless check unit.
// Holds operation codes, controller states and the command and status bundles.
// No dependencies.
package isbc_pkg;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SWEEP_ALL,
        ST_ROW,
        ST_PICK,
        ST_SWEEP_CUT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic accept;
        logic sweep_init;
        logic sweep_step;
        logic cut_active;
        logic set_conn;
        logic clr_bridge;
        logic row_next;
        logic load_cand;
        logic pick;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic subset_empty;
        logic grew;
        logic full;
        logic cand_any;
        logic row_last;
    } status_t;

endpackage

### hw/rtl/isbc_datapath.sv
// Datapath of the bridgeless check unit: adjacency rows, reach sweep, edge candidates.
// Depends on isbc_pkg for the command and status bundles and the operation codes.
module isbc_datapath #(
    parameter int VERTICES = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [1:0]           s_operation,
    input  logic [3:0]           s_vertex_u,
    input  logic [3:0]           s_vertex_v,
    input  logic [15:0]          s_subset_mask,
    input  isbc_pkg::cmd_t       cmd,
    output isbc_pkg::status_t    status,
    output logic                 m_connected,
    output logic                 m_bridgeless
);

    localparam int NV = (VERTICES < 16) ? VERTICES : 16;
    localparam int IW = $clog2(NV);

    logic [NV-1:0] one_reg [NV];
    logic [NV-1:0] two_reg [NV];
    logic [NV-1:0] subset_reg;
    logic [NV-1:0] reach_reg;
    logic [NV-1:0] cand_reg;
    logic [IW-1:0] row_reg;
    logic [IW-1:0] cut_p_reg;
    logic [IW-1:0] cut_q_reg;
    logic          conn_reg;
    logic          bridge_reg;
    logic          m_connected_reg;
    logic          m_bridgeless_reg;

    logic [NV-1:0] eff_row [NV];
    logic [NV-1:0] spread;
    logic [NV-1:0] reach_next;
    logic [NV-1:0] subset_low;
    logic [NV-1:0] cand_low;
    logic [IW-1:0] cand_idx;
    logic [NV-1:0] above;
    logic [NV-1:0] cand_row;
    logic          in_range;

    assign in_range = ({1'b0, s_vertex_u} < 5'(NV)) && ({1'b0, s_vertex_v} < 5'(NV));

    always_comb begin
        spread = '0;
        for (int r = 0; r < NV; r++) begin
            eff_row[r] = one_reg[r];
            if (cmd.cut_active) begin
                if (IW'(r) == cut_p_reg) begin
                    eff_row[r][cut_q_reg] = 1'b0;
                end
                if (IW'(r) == cut_q_reg) begin
                    eff_row[r][cut_p_reg] = 1'b0;
                end
            end
            if (reach_reg[r]) begin
                spread = spread | eff_row[r];
            end
        end
        reach_next = reach_reg | (spread & subset_reg);
    end

    always_comb begin
        subset_low = subset_reg & (~subset_reg + 1'b1);
        cand_low   = cand_reg & (~cand_reg + 1'b1);
        cand_idx   = '0;
        for (int i = 0; i < NV; i++) begin
            if (cand_low[i]) begin
                cand_idx = cand_idx | IW'(i);
            end
        end
        for (int c = 0; c < NV; c++) begin
            above[c] = (c > int'(row_reg));
        end
        cand_row = subset_reg[row_reg]
                 ? (one_reg[row_reg] & ~two_reg[row_reg] & subset_reg & above) : '0;
    end

    always_comb begin
        status.subset_empty = (subset_reg == '0);
        status.grew         = (reach_next != reach_reg);
        status.full         = (reach_reg == subset_reg);
        status.cand_any     = (cand_reg != '0);
        status.row_last     = (row_reg == IW'(NV - 1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < NV; r++) begin
                one_reg[r] <= '0;
                two_reg[r] <= '0;
            end
        end else if (cmd.accept) begin
            if (s_operation == isbc_pkg::OP_CLEAR) begin
                for (int r = 0; r < NV; r++) begin
                    one_reg[r] <= '0;
                    two_reg[r] <= '0;
                end
            end else if (s_operation == isbc_pkg::OP_ADD && in_range) begin
                for (int r = 0; r < NV; r++) begin
                    for (int c = 0; c < NV; c++) begin
                        if ((4'(r) == s_vertex_u && 4'(c) == s_vertex_v) ||
                            (4'(r) == s_vertex_v && 4'(c) == s_vertex_u)) begin
                            if (one_reg[r][c]) begin
                                two_reg[r][c] <= 1'b1;
                            end
                            one_reg[r][c] <= 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reach_reg  <= '0;
            conn_reg   <= 1'b0;
            bridge_reg <= 1'b0;
            row_reg    <= '0;
            cand_reg   <= '0;
        end else begin
            if (cmd.accept && s_operation == isbc_pkg::OP_QUERY) begin
                conn_reg   <= 1'b0;
                bridge_reg <= 1'b0;
            end
            if (cmd.sweep_init || cmd.pick) begin
                reach_reg <= subset_low;
            end else if (cmd.sweep_step) begin
                reach_reg <= reach_next;
            end
            if (cmd.set_conn) begin
                conn_reg   <= 1'b1;
                bridge_reg <= 1'b1;
                row_reg    <= '0;
            end else if (cmd.row_next) begin
                row_reg <= row_reg + 1'b1;
            end
            if (cmd.clr_bridge) begin
                bridge_reg <= 1'b0;
            end
            if (cmd.load_cand) begin
                cand_reg <= cand_row;
            end else if (cmd.pick) begin
                cand_reg <= cand_reg & ~cand_low;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && s_operation == isbc_pkg::OP_QUERY) begin
            subset_reg <= s_subset_mask[NV-1:0];
        end
        if (cmd.pick) begin
            cut_p_reg <= row_reg;
            cut_q_reg <= cand_idx;
        end
        if (cmd.load_out) begin
            m_connected_reg  <= conn_reg;
            m_bridgeless_reg <= bridge_reg;
        end
    end

    assign m_connected  = m_connected_reg;
    assign m_bridgeless = m_bridgeless_reg;

endmodule

### hw/rtl/isbc_ctrl.sv
// Controller of the bridgeless check unit: sequences sweeps and edge removals.
// Depends on isbc_pkg for the state type, the operation codes and the bundles.
module isbc_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_operation,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  isbc_pkg::status_t    status,
    output isbc_pkg::cmd_t       cmd
);

    isbc_pkg::state_t state_reg;
    isbc_pkg::state_t state_next;
    logic             m_valid_reg;
    logic             m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= isbc_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            isbc_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    if (s_operation == isbc_pkg::OP_QUERY) begin
                        state_next = isbc_pkg::ST_START;
                    end
                end
            end
            isbc_pkg::ST_START: begin
                if (status.subset_empty) begin
                    state_next = isbc_pkg::ST_OUT;
                end else begin
                    cmd.sweep_init = 1'b1;
                    state_next     = isbc_pkg::ST_SWEEP_ALL;
                end
            end
            isbc_pkg::ST_SWEEP_ALL: begin
                cmd.sweep_step = 1'b1;
                if (!status.grew) begin
                    if (status.full) begin
                        cmd.set_conn = 1'b1;
                        state_next   = isbc_pkg::ST_ROW;
                    end else begin
                        state_next = isbc_pkg::ST_OUT;
                    end
                end
            end
            isbc_pkg::ST_ROW: begin
                cmd.load_cand = 1'b1;
                state_next    = isbc_pkg::ST_PICK;
            end
            isbc_pkg::ST_PICK: begin
                if (status.cand_any) begin
                    cmd.pick   = 1'b1;
                    state_next = isbc_pkg::ST_SWEEP_CUT;
                end else if (status.row_last) begin
                    state_next = isbc_pkg::ST_OUT;
                end else begin
                    cmd.row_next = 1'b1;
                    state_next   = isbc_pkg::ST_ROW;
                end
            end
            isbc_pkg::ST_SWEEP_CUT: begin
                cmd.cut_active = 1'b1;
                cmd.sweep_step = 1'b1;
                if (!status.grew) begin
                    if (status.full) begin
                        state_next = isbc_pkg::ST_PICK;
                    end else begin
                        cmd.clr_bridge = 1'b1;
                        state_next     = isbc_pkg::ST_OUT;
                    end
                end
            end
            isbc_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = isbc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = isbc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

### hw/rtl/induced_subgraph_bridgeless_check_unit.sv
// Clear and add-edge beats are taken in the idle state. A query beat runs a frontier
// sweep over the vertex rows (at most 16) of the subset; if that reaches every member,
// the unit sweeps again once per single edge inside the subset, with that edge cut,
// until a sweep falls short; the shared frontier sweep over the adjacency rows sets
// the length of a query. A finished result waits in the output register while the
// next beat is taken.
// Top level of the unit; depends on isbc_pkg, isbc_ctrl and isbc_datapath.
module induced_subgraph_bridgeless_check_unit #(
    parameter int VERTICES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [3:0]  s_vertex_u,
    input  logic [3:0]  s_vertex_v,
    input  logic [15:0] s_subset_mask,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_connected,
    output logic        m_bridgeless
);

    isbc_pkg::cmd_t    cmd;
    isbc_pkg::status_t status;

    isbc_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .status      (status),
        .cmd         (cmd)
    );

    isbc_datapath #(
        .VERTICES (VERTICES)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_operation   (s_operation),
        .s_vertex_u    (s_vertex_u),
        .s_vertex_v    (s_vertex_v),
        .s_subset_mask (s_subset_mask),
        .cmd           (cmd),
        .status        (status),
        .m_connected   (m_connected),
        .m_bridgeless  (m_bridgeless)
    );

endmodule

### bench/tb.sv
// Testbench for induced_subgraph_bridgeless_check_unit: keeps its own edge-count table,
// predicts connectivity and bridge answers for every query beat and checks each result beat.
// Depends on isbc_pkg and the unit's RTL.
`timescale 1ns / 100ps

module tb;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int QUIET_TAIL = 40;
    localparam int DRAIN_CYCLES = 2200;

    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  u;
        logic [3:0]  v;
        logic [15:0] mask;
        logic        pause;
    } beat_t;

    typedef struct packed {
        logic connected;
        logic bridgeless;
    } answer_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_operation = isbc_pkg::OP_CLEAR;
    logic [3:0]  s_vertex_u = '0;
    logic [3:0]  s_vertex_v = '0;
    logic [15:0] s_subset_mask = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_connected;
    logic        m_bridgeless;

    beat_t   beat_q[$];
    answer_t answer_q[$];
    logic [1:0] edge_cnt [16][16];
    int  n_items = 0;
    int  bad_beats = 0;
    bit  taken = 1'b0;
    bit  wait_drain = 1'b0;
    int  gap_left = 0;
    int  gap_pct = 20;
    int  sent = 0;
    int  stall_left = 0;
    int  stall_pct = 20;
    int  cycle_cnt = 0;

    induced_subgraph_bridgeless_check_unit #(.VERTICES(16)) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_vertex_u    (s_vertex_u),
        .s_vertex_v    (s_vertex_v),
        .s_subset_mask (s_subset_mask),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_connected   (m_connected),
        .m_bridgeless  (m_bridgeless)
    );

    always #1 aclk = ~aclk;

    initial begin
        for (int i = 0; i < 16; i++) begin
            for (int j = 0; j < 16; j++) begin
                edge_cnt[i][j] = 2'd0;
            end
        end
    end

    function automatic int pick_pct();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 10;
            2: return 30;
            default: return 60;
        endcase
    endfunction

    // Vertices reachable from the lowest member without leaving the subset; a single edge
    // between cut_a and cut_b is treated as removed.
    function automatic logic [15:0] span_from_lowest(input logic [15:0] members,
                                                     input int cut_a, input int cut_b);
        logic [15:0] reach;
        int first;
        bit grew;
        logic [1:0] cnt;
        first = 0;
        while (first < 16 && !members[first]) first++;
        reach = '0;
        reach[first] = 1'b1;
        grew = 1'b1;
        while (grew) begin
            grew = 1'b0;
            for (int p = 0; p < 16; p++) begin
                for (int q = 0; q < 16; q++) begin
                    cnt = edge_cnt[p][q];
                    if (reach[p] && members[q] && !reach[q] && cnt != 2'd0
                            && !(cnt == 2'd1 && ((p == cut_a && q == cut_b)
                                                 || (p == cut_b && q == cut_a)))) begin
                        reach[q] = 1'b1;
                        grew = 1'b1;
                    end
                end
            end
        end
        return reach;
    endfunction

    task automatic track_graph(input logic [1:0] op, input logic [3:0] u, input logic [3:0] v,
                               input logic [15:0] members);
        answer_t ans;
        case (op)
            isbc_pkg::OP_CLEAR: begin
                for (int i = 0; i < 16; i++) begin
                    for (int j = 0; j < 16; j++) begin
                        edge_cnt[i][j] = 2'd0;
                    end
                end
            end
            isbc_pkg::OP_ADD: begin
                if (edge_cnt[u][v] != 2'd2) edge_cnt[u][v] = edge_cnt[u][v] + 2'd1;
                if (u != v && edge_cnt[v][u] != 2'd2) edge_cnt[v][u] = edge_cnt[v][u] + 2'd1;
            end
            isbc_pkg::OP_QUERY: begin
                ans = '0;
                if (members != 16'd0 && span_from_lowest(members, -1, -1) == members) begin
                    ans.connected = 1'b1;
                    ans.bridgeless = 1'b1;
                    for (int p = 0; p < 16; p++) begin
                        for (int q = p + 1; q < 16; q++) begin
                            if (ans.bridgeless && members[p] && members[q]
                                    && edge_cnt[p][q] == 2'd1
                                    && span_from_lowest(members, p, q) != members) begin
                                ans.bridgeless = 1'b0;
                            end
                        end
                    end
                end
                answer_q.push_back(ans);
            end
            default: ;
        endcase
    endtask

    task automatic queue_beat(input logic [1:0] op, input logic [3:0] u, input logic [3:0] v,
                              input logic [15:0] mask);
        beat_t b;
        b.op = op;
        b.u = u;
        b.v = v;
        b.mask = mask;
        b.pause = 1'b0;
        beat_q.push_back(b);
        n_items++;
    endtask

    task automatic queue_pause();
        beat_t b;
        b = '0;
        b.pause = 1'b1;
        beat_q.push_back(b);
    endtask

    always @(posedge aclk) begin
        taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            track_graph(s_operation, s_vertex_u, s_vertex_v, s_subset_mask);
        end
    end

    always @(negedge aclk) begin
        beat_t nxt;
        if (aresetn) begin
            if (taken) begin
                sent++;
                if (sent % 32 == 0) gap_pct = pick_pct();
                if (beat_q.size() >= QUIET_TAIL && $urandom_range(0, 99) < gap_pct) begin
                    gap_left = $urandom_range(1, 10);
                end
            end
            if (taken || !s_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (wait_drain) begin
                    if (answer_q.size() == 0) wait_drain = 1'b0;
                    s_valid <= 1'b0;
                end else if (beat_q.size() != 0) begin
                    nxt = beat_q.pop_front();
                    if (nxt.pause) begin
                        wait_drain = 1'b1;
                        s_valid <= 1'b0;
                    end else begin
                        s_valid <= 1'b1;
                        s_operation <= nxt.op;
                        s_vertex_u <= nxt.u;
                        s_vertex_v <= nxt.v;
                        s_subset_mask <= nxt.mask;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            cycle_cnt++;
            if (cycle_cnt % 50 == 0) stall_pct = pick_pct();
            if (beat_q.size() < QUIET_TAIL) begin
                stall_left = 0;
                m_ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if ($urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(1, 10) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        answer_t exp_ans;
        if (aresetn && m_valid && m_ready) begin
            if (answer_q.size() == 0) begin
                $error("result beat with nothing pending: connected=%0d bridgeless=%0d",
                       m_connected, m_bridgeless);
                bad_beats++;
            end else begin
                exp_ans = answer_q.pop_front();
                if (m_connected !== exp_ans.connected) begin
                    $error("connected: expected %0d, actual %0d",
                           exp_ans.connected, m_connected);
                    bad_beats++;
                end
                if (m_bridgeless !== exp_ans.bridgeless) begin
                    $error("bridgeless: expected %0d, actual %0d",
                           exp_ans.bridgeless, m_bridgeless);
                    bad_beats++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("tb NOT OK");
        $finish;
    end

    initial begin
        int order [16];
        int nv;
        int swap_at;
        int tmp;
        int nq;
        logic [15:0] vset;
        logic [15:0] qmask;
        bit paused_mid;

        paused_mid = 1'b0;
        queue_beat(isbc_pkg::OP_QUERY, 4'd0, 4'd0, 16'h0000);
        queue_beat(isbc_pkg::OP_QUERY, 4'd15, 4'd15, 16'h0001);
        queue_beat(isbc_pkg::OP_ADD, 4'd0, 4'd1, 16'h0000);
        queue_beat(isbc_pkg::OP_QUERY, 4'd0, 4'd0, 16'h0003);
        queue_beat(isbc_pkg::OP_ADD, 4'd1, 4'd0, 16'hFFFF);
        queue_beat(isbc_pkg::OP_QUERY, 4'd0, 4'd0, 16'h0003);
        queue_beat(isbc_pkg::OP_ADD, 4'd2, 4'd2, 16'h0000);
        queue_beat(isbc_pkg::OP_QUERY, 4'd0, 4'd0, 16'h0004);
        queue_beat(isbc_pkg::OP_QUERY, 4'd0, 4'd0, 16'h0005);
        queue_beat(isbc_pkg::OP_ADD, 4'd1, 4'd2, 16'h0000);
        queue_beat(isbc_pkg::OP_QUERY, 4'd0, 4'd0, 16'h0007);
        queue_beat(isbc_pkg::OP_ADD, 4'd2, 4'd0, 16'h0000);
        queue_beat(isbc_pkg::OP_QUERY, 4'd0, 4'd0, 16'h0007);
        queue_beat(OP_UNUSED, 4'd15, 4'd15, 16'hFFFF);
        queue_beat(isbc_pkg::OP_QUERY, 4'd0, 4'd0, 16'h0007);
        queue_beat(isbc_pkg::OP_ADD, 4'd15, 4'd15, 16'h0000);
        queue_beat(isbc_pkg::OP_ADD, 4'd14, 4'd15, 16'h0000);
        queue_beat(isbc_pkg::OP_QUERY, 4'd0, 4'd0, 16'hC000);
        queue_beat(isbc_pkg::OP_QUERY, 4'd0, 4'd0, 16'hFFFF);
        queue_beat(isbc_pkg::OP_CLEAR, 4'd15, 4'd15, 16'hFFFF);
        queue_beat(isbc_pkg::OP_QUERY, 4'd0, 4'd0, 16'hFFFF);
        queue_beat(isbc_pkg::OP_QUERY, 4'd0, 4'd0, 16'h8000);
        queue_beat(isbc_pkg::OP_ADD, 4'd15, 4'd0, 16'h0000);
        queue_beat(isbc_pkg::OP_QUERY, 4'd0, 4'd0, 16'h8001);
        queue_pause();

        while (n_items < 290) begin
            for (int i = 0; i < 16; i++) order[i] = i;
            for (int i = 15; i > 0; i--) begin
                swap_at = $urandom_range(0, i);
                tmp = order[i];
                order[i] = order[swap_at];
                order[swap_at] = tmp;
            end
            nv = ($urandom_range(0, 7) == 0) ? 16 : $urandom_range(2, 7);
            vset = '0;
            for (int i = 0; i < nv; i++) vset[order[i]] = 1'b1;
            if ($urandom_range(0, 4) != 0) begin
                queue_beat(isbc_pkg::OP_CLEAR, 4'($urandom_range(0, 15)),
                           4'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)));
            end
            if ($urandom_range(0, 1) == 0) begin
                for (int i = 0; i < nv; i++) begin
                    queue_beat(isbc_pkg::OP_ADD, 4'(order[i]), 4'(order[(i + 1) % nv]),
                               16'($urandom_range(0, 65535)));
                end
            end else begin
                for (int i = 1; i < nv; i++) begin
                    queue_beat(isbc_pkg::OP_ADD, 4'(order[i]),
                               4'(order[$urandom_range(0, i - 1)]),
                               16'($urandom_range(0, 65535)));
                end
            end
            for (int i = $urandom_range(0, 3); i > 0; i--) begin
                queue_beat(isbc_pkg::OP_ADD, 4'(order[$urandom_range(0, nv - 1)]),
                           4'(order[$urandom_range(0, nv - 1)]),
                           16'($urandom_range(0, 65535)));
            end
            nq = $urandom_range(2, 5);
            for (int i = 0; i < nq; i++) begin
                case ($urandom_range(0, 5))
                    0, 1: qmask = vset;
                    2: qmask = vset & 16'($urandom_range(0, 65535));
                    3: qmask = vset & ~(16'd1 << order[$urandom_range(0, nv - 1)]);
                    4: qmask = 16'($urandom_range(0, 65535));
                    default: begin
                        qmask = vset;
                        queue_beat($urandom_range(0, 1) ? OP_UNUSED : isbc_pkg::OP_ADD,
                                   4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                                   16'($urandom_range(0, 65535)));
                    end
                endcase
                queue_beat(isbc_pkg::OP_QUERY, 4'($urandom_range(0, 15)),
                           4'($urandom_range(0, 15)), qmask);
            end
            if (!paused_mid && n_items >= 150) begin
                queue_pause();
                paused_mid = 1'b1;
            end
        end

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        while (beat_q.size() != 0 || s_valid || wait_drain) @(posedge aclk);
        while (answer_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (bad_beats == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/isbc_pkg.sv
hw/rtl/isbc_datapath.sv
hw/rtl/isbc_ctrl.sv
hw/rtl/induced_subgraph_bridgeless_check_unit.sv
bench/tb.sv
